/* src/sahfsa_pkg.sv */
// Shared constants, codes and types for the handle allocator.
`default_nettype none
package sahfsa_pkg;

	localparam int ENTRY_COUNT = 16384;
	localparam int IDX_W       = $clog2(ENTRY_COUNT);
	localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);
	localparam int HANDLE_W    = 15;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 3;
	localparam int CMP_W       = ((HANDLE_W > CNT_W) ? HANDLE_W : CNT_W) + 1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 2'd0,
		FN_DELETE  = 2'd1,
		FN_RELEASE = 2'd2,
		FN_LOOKUP  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_SPACE   = 3'd1,
		ST_NO_OFFLOAD = 3'd2,
		ST_RANGE      = 3'd3,
		ST_UNUSED     = 3'd4,
		ST_REPEAT_INV = 3'd5,
		ST_DOUBLE_REL = 3'd6
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

/* src/sahfsa_req_if.sv */
// Request channel: operation and handle.
`default_nettype none
interface sahfsa_req_if;
	logic                              valid;
	logic                              ready;
	logic [sahfsa_pkg::FUNC_W-1:0]     func;
	logic [sahfsa_pkg::HANDLE_W-1:0]   handle;

	modport source (output valid, output func, output handle, input ready);
	modport sink (input valid, input func, input handle, output ready);
endinterface
`default_nettype wire

/* src/sahfsa_rsp_if.sv */
// Response channel: status, handle and invalidate flag.
`default_nettype none
interface sahfsa_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [sahfsa_pkg::STATUS_W-1:0]   status;
	logic [sahfsa_pkg::HANDLE_W-1:0]   handle_out;
	logic                              send_invalidate;

	modport source (output valid, output status, output handle_out,
		output send_invalidate, input ready);
	modport sink (input valid, input status, input handle_out,
		input send_invalidate, output ready);
endinterface
`default_nettype wire

/* src/sa_handle_free_stack_allocator.sv */
// Top level of the security-association handle allocator.
// Each request is accepted in the idle state, in which the free-stack and
// entry-flag memories are read; in the execute step the result is computed,
// the memories are written and the response register loaded. A new request
// is accepted only once the controller is back in idle, so a request is not
// taken before the last one has committed; a held response stalls only the
// execute step. Both memories have one read and at most one write per request.
// No clearing pass follows reset: stack slots never written read as the
// reset ordering and entry flags above the allocation high mark read as zero.
`default_nettype none
module sa_handle_free_stack_allocator (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sahfsa_req_if.sink    req,
	sahfsa_rsp_if.source  rsp
);

	sahfsa_pkg::cmd_t cmd;

	sahfsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	sahfsa_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.req_func            (req.func),
		.req_handle          (req.handle),
		.rsp_status          (rsp.status),
		.rsp_handle_out      (rsp.handle_out),
		.rsp_send_invalidate (rsp.send_invalidate)
	);

endmodule
`default_nettype wire

/* src/sahfsa_ctrl.sv */
// Controller: request acceptance, execute step and response valid.
`default_nettype none
module sahfsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output sahfsa_pkg::cmd_t       cmd
);

	sahfsa_pkg::state_t state_q;
	sahfsa_pkg::state_t state_d;
	logic               rsp_valid_q;
	logic               rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sahfsa_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			sahfsa_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = sahfsa_pkg::S_EXEC;
				end
			end
			sahfsa_pkg::S_EXEC: begin
				cmd.commit = !rsp_valid_q || rsp_ready;
				if (cmd.commit) begin
					state_d = sahfsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sahfsa_pkg::S_IDLE;
			end
		endcase
		if (cmd.commit) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == sahfsa_pkg::S_EXEC))
		else $error("accepted request did not reach execute");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed result not presented");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && cmd.commit))
		else $error("accept and commit in the same cycle");

endmodule
`default_nettype wire

/* src/sahfsa_dp.sv */
// Datapath: free stack, entry flags, counters and result register.
`default_nettype none
module sahfsa_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sahfsa_pkg::cmd_t                  cmd,
	input  wire logic [sahfsa_pkg::FUNC_W-1:0]     req_func,
	input  wire logic [sahfsa_pkg::HANDLE_W-1:0]   req_handle,
	output logic [sahfsa_pkg::STATUS_W-1:0]        rsp_status,
	output logic [sahfsa_pkg::HANDLE_W-1:0]        rsp_handle_out,
	output logic                                   rsp_send_invalidate
);

	localparam int IDX_W    = sahfsa_pkg::IDX_W;
	localparam int CNT_W    = sahfsa_pkg::CNT_W;
	localparam int HANDLE_W = sahfsa_pkg::HANDLE_W;
	localparam int CMP_W    = sahfsa_pkg::CMP_W;
	localparam int ENTRIES  = sahfsa_pkg::ENTRY_COUNT;

	// flag bit 0: in use, bit 1: invalidated
	logic [IDX_W-1:0]             stack_mem [ENTRIES];
	logic [1:0]                   flag_mem [ENTRIES];

	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             low_q;
	logic [sahfsa_pkg::FUNC_W-1:0] func_q;
	logic [HANDLE_W-1:0]          handle_q;
	logic [IDX_W-1:0]             stack_rd_q;
	logic [1:0]                   flag_rd_q;
	logic [sahfsa_pkg::STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0]          hout_q;
	logic                         inv_q;

	sahfsa_pkg::status_t          status_d;
	logic [HANDLE_W-1:0]          hout_d;
	logic                         inv_d;
	logic [CNT_W-1:0]             count_d;
	logic [CNT_W-1:0]             low_d;
	logic                         flag_we;
	logic [IDX_W-1:0]             flag_wa;
	logic [1:0]                   flag_wd;
	logic                         stack_we;
	logic [IDX_W-1:0]             rel_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(ENTRIES);
			low_q   <= CNT_W'(ENTRIES);
		end else if (cmd.commit) begin
			count_q <= count_d;
			low_q   <= low_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q     <= req_func;
			handle_q   <= req_handle;
			stack_rd_q <= stack_mem[IDX_W'(count_q - CNT_W'(1))];
			flag_rd_q  <= flag_mem[IDX_W'(req_handle - HANDLE_W'(1))];
		end
		if (cmd.commit) begin
			status_q <= status_d;
			hout_q   <= hout_d;
			inv_q    <= inv_d;
		end
		if (cmd.commit && flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		if (cmd.commit && stack_we) begin
			stack_mem[IDX_W'(count_q)] <= rel_idx;
		end
	end

	always_comb begin
		logic [CNT_W-1:0] pos;
		logic [IDX_W-1:0] pop_idx;
		logic [CNT_W-1:0] lim;
		logic [CMP_W-1:0] hext;
		logic             in_use;
		logic             invd;
		pos      = count_q - CNT_W'(1);
		pop_idx  = (pos < low_q) ? IDX_W'(CNT_W'(ENTRIES - 1) - pos) : stack_rd_q;
		lim      = CNT_W'(ENTRIES) - low_q;
		hext     = CMP_W'(handle_q);
		rel_idx  = IDX_W'(handle_q - HANDLE_W'(1));
		in_use   = (CNT_W'(rel_idx) < lim) && flag_rd_q[0];
		invd     = (CNT_W'(rel_idx) < lim) && flag_rd_q[1];
		status_d = sahfsa_pkg::ST_OK;
		hout_d   = handle_q;
		inv_d    = 1'b0;
		count_d  = count_q;
		low_d    = low_q;
		flag_we  = 1'b0;
		flag_wa  = rel_idx;
		flag_wd  = 2'b00;
		stack_we = 1'b0;
		if (sahfsa_pkg::func_t'(func_q) == sahfsa_pkg::FN_ALLOC) begin
			if (count_q == '0) begin
				status_d = sahfsa_pkg::ST_NO_SPACE;
				hout_d   = '0;
			end else begin
				count_d = pos;
				low_d   = (pos < low_q) ? pos : low_q;
				flag_we = 1'b1;
				flag_wa = pop_idx;
				flag_wd = 2'b01;
				hout_d  = HANDLE_W'(CMP_W'(pop_idx) + CMP_W'(1));
			end
		end else if (handle_q == '0) begin
			status_d = sahfsa_pkg::ST_NO_OFFLOAD;
		end else if (hext > CMP_W'(ENTRIES)) begin
			status_d = sahfsa_pkg::ST_RANGE;
		end else begin
			unique case (sahfsa_pkg::func_t'(func_q))
				sahfsa_pkg::FN_DELETE: begin
					if (!in_use) begin
						status_d = sahfsa_pkg::ST_UNUSED;
					end else if (invd) begin
						status_d = sahfsa_pkg::ST_REPEAT_INV;
					end else begin
						inv_d   = 1'b1;
						flag_we = 1'b1;
						flag_wd = 2'b11;
					end
				end
				sahfsa_pkg::FN_RELEASE: begin
					if (!in_use || count_q >= CNT_W'(ENTRIES)) begin
						status_d = sahfsa_pkg::ST_DOUBLE_REL;
					end else begin
						inv_d    = !invd;
						flag_we  = 1'b1;
						flag_wd  = 2'b10;
						stack_we = 1'b1;
						count_d  = count_q + CNT_W'(1);
					end
				end
				default: begin
					if (!in_use) begin
						status_d = sahfsa_pkg::ST_UNUSED;
					end
				end
			endcase
		end
	end

	assign rsp_status          = status_q;
	assign rsp_handle_out      = hout_q;
	assign rsp_send_invalidate = inv_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(ENTRIES)) && (low_q <= count_q))
		else $error("free count or low mark out of bounds");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q) && $stable(low_q))
		else $error("free count moved without a commit");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (count_q == $past(count_q)) ||
			(count_q == $past(count_q) + CNT_W'(1)) ||
			(count_q == $past(count_q) - CNT_W'(1)))
		else $error("free count changed by more than one");

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for the security-association handle allocator: request driver, response checker.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sahfsa_pkg::*;

	typedef struct packed {
		func_t                 func;
		logic [HANDLE_W-1:0]   handle;
	} sa_req_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle;
		logic                  inv;
	} sa_rsp_t;

	logic clk;
	logic arst_n;

	sahfsa_req_if req_ch ();
	sahfsa_rsp_if rsp_ch ();

	sa_handle_free_stack_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [IDX_W-1:0] free_idx [ENTRY_COUNT];
	logic             in_use [ENTRY_COUNT];
	logic             inval_sent [ENTRY_COUNT];
	int               free_cnt;

	sa_req_t pending [$];
	sa_rsp_t awaited [$];
	sa_req_t next_req;
	sa_rsp_t got_rsp;
	sa_rsp_t want_rsp;

	int send_idle;
	int recv_stall;
	int n_req;
	int n_rsp;
	int n_err;
	int n_nospace;
	int n_inv;
	int n_range;

	function automatic sa_rsp_t sa_table_step(func_t fn, logic [HANDLE_W-1:0] h);
		sa_rsp_t          r;
		logic [IDX_W-1:0] idx;
		r.status = ST_OK;
		r.handle = h;
		r.inv    = 1'b0;
		if (fn == FN_ALLOC) begin
			if (free_cnt == 0 || free_cnt > ENTRY_COUNT) begin
				r.status = ST_NO_SPACE;
				r.handle = '0;
			end else begin
				free_cnt--;
				idx             = free_idx[free_cnt];
				in_use[idx]     = 1'b1;
				inval_sent[idx] = 1'b0;
				r.handle        = HANDLE_W'(idx) + HANDLE_W'(1);
			end
		end else if (h == '0) begin
			r.status = ST_NO_OFFLOAD;
		end else if (int'(h) > ENTRY_COUNT) begin
			r.status = ST_RANGE;
		end else begin
			idx = IDX_W'(h - HANDLE_W'(1));
			case (fn)
				FN_DELETE: begin
					if (!in_use[idx]) begin
						r.status = ST_UNUSED;
					end else if (inval_sent[idx]) begin
						r.status = ST_REPEAT_INV;
					end else begin
						r.inv           = 1'b1;
						inval_sent[idx] = 1'b1;
					end
				end
				FN_RELEASE: begin
					if (!in_use[idx] || free_cnt >= ENTRY_COUNT) begin
						r.status = ST_DOUBLE_REL;
					end else begin
						r.inv              = !inval_sent[idx];
						inval_sent[idx]    = 1'b1;
						in_use[idx]        = 1'b0;
						free_idx[free_cnt] = idx;
						free_cnt++;
					end
				end
				default: begin
					if (!in_use[idx])
						r.status = ST_UNUSED;
				end
			endcase
		end
		return r;
	endfunction

	task automatic add_req(func_t fn, int h);
		sa_req_t r;
		r.func   = fn;
		r.handle = HANDLE_W'(h);
		pending.push_back(r);
	endtask

	task automatic add_random(int n);
		sa_req_t r;
		int      pick;
		repeat (n) begin
			pick   = $urandom_range(99);
			r.func = (pick < 25) ? FN_ALLOC : (pick < 45) ? FN_DELETE :
				(pick < 75) ? FN_RELEASE : FN_LOOKUP;
			pick   = $urandom_range(99);
			if (pick < 84)
				r.handle = HANDLE_W'($urandom_range(24, 1));
			else if (pick < 89)
				r.handle = '0;
			else if (pick < 94)
				r.handle = HANDLE_W'($urandom_range(32767, ENTRY_COUNT + 1));
			else
				r.handle = HANDLE_W'($urandom_range(ENTRY_COUNT, 1));
			pending.push_back(r);
		end
	endtask

	task automatic drain();
		while (pending.size() != 0 || req_ch.valid || awaited.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("timeout with %0d responses outstanding", awaited.size());
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.func   <= FN_ALLOC;
			req_ch.handle <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_req = pending.pop_front();
				req_ch.valid  <= 1'b1;
				req_ch.func   <= next_req.func;
				req_ch.handle <= next_req.handle;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				want_rsp = sa_table_step(func_t'(req_ch.func), req_ch.handle);
				awaited.push_back(want_rsp);
				n_req++;
				if (want_rsp.status == ST_NO_SPACE)
					n_nospace++;
				if (want_rsp.status == ST_RANGE)
					n_range++;
				if (want_rsp.inv)
					n_inv++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_rsp.status = status_t'(rsp_ch.status);
				got_rsp.handle = rsp_ch.handle_out;
				got_rsp.inv    = rsp_ch.send_invalidate;
				n_rsp++;
				if (awaited.size() == 0) begin
					if (n_err < 10)
						$display("unexpected response: status %0d handle %0d inv %0b",
							got_rsp.status, got_rsp.handle, got_rsp.inv);
					n_err++;
				end else begin
					want_rsp = awaited.pop_front();
					if (got_rsp !== want_rsp) begin
						if (n_err < 10)
							$display("mismatch: status %0d/%0d handle %0d/%0d inv %0b/%0b (exp/got)",
								want_rsp.status, got_rsp.status, want_rsp.handle,
								got_rsp.handle, want_rsp.inv, got_rsp.inv);
						n_err++;
					end
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.func   = FN_ALLOC;
		req_ch.handle = '0;
		rsp_ch.ready  = 1'b0;
		send_idle     = 0;
		recv_stall    = 0;
		n_req         = 0;
		n_rsp         = 0;
		n_err         = 0;
		n_nospace     = 0;
		n_inv         = 0;
		n_range       = 0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			free_idx[i]   = IDX_W'(ENTRY_COUNT - 1 - i);
			in_use[i]     = 1'b0;
			inval_sent[i] = 1'b0;
		end
		free_cnt = ENTRY_COUNT;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		add_req(FN_ALLOC, 0);
		add_req(FN_ALLOC, 32767);
		add_req(FN_DELETE, 1);
		add_req(FN_DELETE, 1);
		add_req(FN_LOOKUP, 1);
		add_req(FN_RELEASE, 1);
		add_req(FN_RELEASE, 1);
		add_req(FN_LOOKUP, 1);
		add_req(FN_DELETE, 1);
		add_req(FN_RELEASE, 2);
		add_req(FN_LOOKUP, 0);
		add_req(FN_DELETE, 0);
		add_req(FN_RELEASE, 0);
		add_req(FN_LOOKUP, ENTRY_COUNT + 1);
		add_req(FN_DELETE, 32767);
		add_req(FN_RELEASE, ENTRY_COUNT + 1);
		add_req(FN_LOOKUP, ENTRY_COUNT);
		add_req(FN_RELEASE, ENTRY_COUNT);
		add_req(FN_ALLOC, 21845);
		add_req(FN_ALLOC, 10922);
		add_req(FN_LOOKUP, 2);
		add_req(FN_RELEASE, 1);
		add_req(FN_DELETE, 2);
		add_req(FN_LOOKUP, 16383);
		add_random(150);
		drain();

		send_idle  = 76;
		recv_stall = 0;
		add_random(150);
		drain();

		send_idle  = 0;
		recv_stall = 76;
		add_random(150);
		drain();

		send_idle  = 20;
		recv_stall = 20;
		add_random(150);
		drain();

		// probe the last entry and the edge of the table
		send_idle  = 0;
		recv_stall = 0;
		add_req(FN_LOOKUP, ENTRY_COUNT);
		add_req(FN_DELETE, ENTRY_COUNT);
		add_req(FN_DELETE, ENTRY_COUNT);
		add_req(FN_RELEASE, ENTRY_COUNT);
		add_req(FN_ALLOC, 0);
		add_req(FN_RELEASE, 1);
		add_req(FN_RELEASE, 100);
		add_req(FN_ALLOC, 0);
		add_req(FN_ALLOC, 0);
		add_req(FN_ALLOC, 0);
		add_req(FN_LOOKUP, 100);
		add_random(20);
		drain();

		repeat (20) @(posedge clk);
		if (awaited.size() != 0)
			n_err++;
		$display("%0d requests, %0d responses checked, %0d mismatches", n_req, n_rsp, n_err);
		$display("covered: %0d no-space, %0d out-of-range, %0d invalidates sent",
			n_nospace, n_range, n_inv);
		if (n_err == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
